[hdl/imaw_pkg.sv]
// Shared types, constants and step tables of the IMA ADPCM word decoder.
package imaw_pkg;

	localparam int unsigned CodesPerWord = 8;
	localparam logic [6:0] IdxMax = 7'd88;
	localparam logic [2:0] LastCode = 3'd7;
	localparam logic signed [17:0] SampleMax = 18'sd32767;
	localparam logic signed [17:0] SampleMin = -18'sd32767;

	// Item kinds carried in tuser on the input side.
	localparam logic ModeDecode = 1'b0;
	localparam logic ModeLoad = 1'b1;

	// Classified item as it travels from the front part to the back part.
	typedef struct packed {
		logic is_load;
		logic [31:0] word;
		logic signed [15:0] sample;
		logic [6:0] index;
	} cmd_t;

	localparam logic [14:0] StepRom [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
		15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
		15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
		15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
		15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
		15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
		15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
		15'd29794, 15'd32767
	};

	function automatic logic [14:0] step_lookup(input logic [6:0] idx);
		logic [14:0] val;
		if (idx > IdxMax) begin
			val = StepRom[88];
		end else begin
			val = StepRom[idx];
		end
		return val;
	endfunction

	function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
		logic signed [4:0] adj;
		unique case (mag)
			3'd0, 3'd1, 3'd2, 3'd3: adj = -5'sd1;
			3'd4: adj = 5'sd2;
			3'd5: adj = 5'sd4;
			3'd6: adj = 5'sd6;
			3'd7: adj = 5'sd8;
			default: adj = 5'sd0;
		endcase
		return adj;
	endfunction

endpackage

[hdl/imaw_front.sv]
// Front part: accepts input transfers and classifies them into load or decode commands.
module imaw_front import imaw_pkg::*; (
	input logic s_tvalid,
	output logic s_tready,
	input logic [55:0] s_tdata,
	input logic s_tuser,
	input logic q_full,
	output logic q_push,
	output cmd_t q_cmd
);

	assign s_tready = !q_full;
	assign q_push = s_tvalid && !q_full;

	// Saturate the start index here so the back part only ever sees 0..88.
	always_comb begin
		q_cmd.is_load = (s_tuser == ModeLoad);
		q_cmd.word = s_tdata[31:0];
		q_cmd.sample = $signed(s_tdata[47:32]);
		q_cmd.index = (s_tdata[54:48] > IdxMax) ? IdxMax : s_tdata[54:48];
	end

endmodule

[hdl/imaw_fifo.sv]
// Short command queue between the front and back parts.
module imaw_fifo import imaw_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	output logic full,
	input logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	cmd_t entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CntFull);
	assign head_valid = (count_q != '0);
	assign head_cmd = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/imaw_back.sv]
// Back part: decodes one code per cycle when not stalled into the registered output.
module imaw_back import imaw_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input cmd_t head_cmd,
	output logic pop,
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata,
	output logic m_tlast
);

	logic busy_q;
	logic [2:0] cnt_q;
	logic [31:0] word_q;
	logic signed [15:0] pred_q;
	logic [6:0] idx_q;
	logic out_valid_q;
	logic [15:0] out_sample_q;
	logic out_last_q;

	logic adv;
	logic finish;
	logic [3:0] code;
	logic [14:0] step;
	logic [16:0] diff;
	logic signed [17:0] pred_ext;
	logic signed [17:0] raw;
	logic signed [15:0] pred_next;
	logic signed [7:0] idx_sum;
	logic [6:0] idx_next;

	assign adv = busy_q && (!out_valid_q || m_tready);
	assign finish = adv && (cnt_q == LastCode);
	assign pop = head_valid && (!busy_q || finish);

	assign code = word_q[3:0];
	assign step = step_lookup(idx_q);

	always_comb begin
		diff = {5'd0, step[14:3]};
		if (code[0]) begin
			diff = diff + {4'd0, step[14:2]};
		end
		if (code[1]) begin
			diff = diff + {3'd0, step[14:1]};
		end
		if (code[2]) begin
			diff = diff + {2'd0, step};
		end
	end

	// Clamp only on the side the difference moved toward.
	always_comb begin
		pred_ext = {{2{pred_q[15]}}, pred_q};
		if (code[3]) begin
			raw = pred_ext + $signed({1'b0, diff});
			pred_next = (raw > SampleMax) ? SampleMax[15:0] : raw[15:0];
		end else begin
			raw = pred_ext - $signed({1'b0, diff});
			pred_next = (raw < SampleMin) ? SampleMin[15:0] : raw[15:0];
		end
	end

	always_comb begin
		idx_sum = $signed({1'b0, idx_q}) + 8'(index_adjust(code[2:0]));
		if (idx_sum < 8'sd0) begin
			idx_next = '0;
		end else if (idx_sum > $signed({1'b0, IdxMax})) begin
			idx_next = IdxMax;
		end else begin
			idx_next = idx_sum[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			pred_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A load popped on the last code of a word follows it, so it wins.
			if (pop && head_cmd.is_load) begin
				pred_q <= head_cmd.sample;
				idx_q <= head_cmd.index;
			end else if (adv) begin
				pred_q <= pred_next;
				idx_q <= idx_next;
			end
			if (pop && !head_cmd.is_load) begin
				cnt_q <= '0;
			end else if (adv) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pop && !head_cmd.is_load) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !head_cmd.is_load) begin
			word_q <= head_cmd.word;
		end else if (adv) begin
			word_q <= {4'd0, word_q[31:4]};
		end
		if (adv) begin
			out_sample_q <= pred_next;
			out_last_q <= (cnt_q == LastCode);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_sample_q;
	assign m_tlast = out_last_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IdxMax)
		else $error("step index left 0..88");

	a_last_marks_eighth: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q && out_last_q)
		else $error("eighth sample not marked last");

	a_idle_after_eighth: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(cnt_q) == LastCode)
		else $error("decoder went idle before the eighth code");

	a_no_pop_midword: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != LastCode |-> !pop)
		else $error("command taken while a word is still decoding");

endmodule

[hdl/ima_adpcm_word_decoder.sv]
// Top level of the IMA ADPCM word decoder: front part, command queue and back part.
//
// The block decodes IMA ADPCM words into 16-bit PCM. An input transfer with tuser set
// loads the predictor and the step index (an index above 88 is saturated to 88) and
// produces no output; a transfer with tuser clear brings a 32-bit word of eight 4-bit
// codes, decoded low nibble first, and produces eight sample transfers, the eighth with
// tlast high. Each code adds or subtracts step/8 plus the selected step fractions, clamps
// to +-32767 on the side it moved toward, and steps the index through the adjust table.
// Rate: the back part runs one code per cycle through the step table lookup, the difference
// adder and the clamp, and words follow one another without a gap while the output is
// taken every cycle. The front part keeps accepting items, while there is room, into a
// QUEUE_DEPTH-entry command queue while the back part works. The output register holds a
// finished sample until it is taken; while it waits, the back part holds on the current
// code and advances again in the cycle the sample transfer happens.
module ima_adpcm_word_decoder import imaw_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [55:0] s_tdata, // data_word[31:0], start_sample[47:32], start_index[54:48], 0
	input logic s_tuser, // mode: 0 decode, 1 load
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata, // sample[15:0]
	output logic m_tlast
);

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	// Accept and classify transfers, saturating the load index.
	imaw_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	// Hold commands until the back part is ready for them.
	imaw_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	// Apply loads and advance one code per cycle, while the output is taken, through each data word.
	imaw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule
